[hw/rtl/urrs_pkg.sv]
// Shared constants for the uniform range rejection sampler.
`default_nettype none

package urrs_pkg;

  // Width of the payload fields on the channels
  localparam int FIELD_BITS = 64;

  // Input operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_WORD    = 1'b1;

  // Result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_RANGE = 1'b1;

  // Control between the sequencer and the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

[hw/rtl/urrs_if.sv]
// Valid/ready channel interfaces for request/word items and result items.
`default_nettype none

interface urrs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [urrs_pkg::FIELD_BITS-1:0]   lower_bound;
  logic [urrs_pkg::FIELD_BITS-1:0]   upper_bound;
  logic [urrs_pkg::FIELD_BITS-1:0]   random_word;

  modport source (output valid, operation, lower_bound, upper_bound, random_word,
                  input ready);
  modport sink   (input valid, operation, lower_bound, upper_bound, random_word,
                  output ready);
endinterface

interface urrs_out_if;
  logic                              valid;
  logic                              ready;
  logic [urrs_pkg::FIELD_BITS-1:0]   sample_value;
  logic                              status;

  modport source (output valid, sample_value, status, input ready);
  modport sink   (input valid, sample_value, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/urrs_mod.sv]
// Serial remainder unit: restoring division, one quotient bit per cycle.
`default_nettype none

module urrs_mod #(
  parameter int W = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [W-1:0]          dividend,
  input  wire logic [W-1:0]          divisor,
  output urrs_pkg::mod_stat_t        stat,
  output logic      [W-1:0]          remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     shift_r;
  logic [W-1:0]     rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // Trial subtract of the divisor from the partial remainder
  logic [W:0] trial;
  logic [W:0] diff;
  assign trial = {rem_r, shift_r[W-1]};
  assign diff  = trial - {1'b0, divisor};

  // Control: bit counter and busy/done flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out MSB first into the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= {shift_r[W-2:0], 1'b0};
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
      end else begin
        rem_r <= trial[W-1:0];
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[hw/rtl/uniform_range_rejection_sampler.sv]
// Top level: uniform range sampler with rejection, built on a serial remainder unit.
`default_nettype none

// Range requests and raw random words arrive on one channel. A good request
// has its cutoff remainder found one bit per cycle in the serial unit and
// gives no result; a bad range gives an error result. A random word that is
// dropped or rejected gives no result; an accepted word gives a result, its
// remainder again found one bit per cycle. One item is worked on at a time; a
// finished result sits in the output register while the next item is taken in.

module uniform_range_rejection_sampler #(
  parameter int WORD_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  urrs_in_if.sink    in_ch,
  urrs_out_if.source out_ch
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] MAXWORD = {W{1'b1}};

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CUT  = 2'd1;
  localparam logic [1:0] ST_SAMP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic         pending_r;
  logic [W-1:0] lower_r;
  logic [W-1:0] span_r;
  logic [W-1:0] cutoff_r;
  logic [W-1:0] res_value_r;
  logic         res_status_r;
  logic         out_valid_r;
  logic [W-1:0] out_value_r;
  logic         out_status_r;

  // Input fields cut to the word width
  logic [W-1:0] in_lo, in_hi, in_word, span_calc;
  logic         accept, bad_range, word_ok, mod_start, out_free;
  logic [W-1:0] mod_dividend, mod_rem;
  urrs_pkg::mod_stat_t mod_stat;

  assign in_lo     = in_ch.lower_bound[W-1:0];
  assign in_hi     = in_ch.upper_bound[W-1:0];
  assign in_word   = in_ch.random_word[W-1:0];
  assign span_calc = in_hi - in_lo;
  assign bad_range = (in_lo >= in_hi) || (span_calc == MAXWORD);
  assign word_ok   = pending_r && (span_r != '0) && (in_word < cutoff_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Start the remainder unit for a good request or an accepted word
  assign mod_start = accept &&
                     (((in_ch.operation == urrs_pkg::OP_REQUEST) && !bad_range) ||
                      ((in_ch.operation == urrs_pkg::OP_WORD) && word_ok));
  assign mod_dividend = (in_ch.operation == urrs_pkg::OP_REQUEST) ? MAXWORD : in_word;

  urrs_mod #(.W(W)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (span_r),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.operation == urrs_pkg::OP_REQUEST) begin
            state_nxt = bad_range ? ST_EMIT : ST_CUT;
          end else if (word_ok) begin
            state_nxt = ST_SAMP;
          end
        end
      end
      ST_CUT:  if (mod_stat.done) state_nxt = ST_IDLE;
      ST_SAMP: if (mod_stat.done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_ch.operation == urrs_pkg::OP_REQUEST)) begin
        pending_r <= 1'b0;
      end else if ((state_r == ST_CUT) && mod_stat.done) begin
        pending_r <= 1'b1;
      end else if ((state_r == ST_SAMP) && mod_stat.done) begin
        pending_r <= 1'b0;
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: stored request, pending result, output register
  always_ff @(posedge clk) begin
    if (accept && (in_ch.operation == urrs_pkg::OP_REQUEST)) begin
      if (bad_range) begin
        res_value_r  <= '0;
        res_status_r <= urrs_pkg::STATUS_BAD_RANGE;
      end else begin
        lower_r <= in_lo;
        span_r  <= span_calc;
      end
    end
    if ((state_r == ST_CUT) && mod_stat.done) begin
      cutoff_r <= MAXWORD - mod_rem;
    end
    if ((state_r == ST_SAMP) && mod_stat.done) begin
      res_value_r  <= lower_r + mod_rem;
      res_status_r <= urrs_pkg::STATUS_OK;
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = urrs_pkg::FIELD_BITS'(out_value_r);
  assign out_ch.status       = out_status_r;

endmodule

`default_nettype wire

[hw/rtl/urrs_checker.sv]
// Port-level checker for the sampler, bound to the top level.
`default_nettype none

module urrs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_sample_value,
  input wire logic        out_status
);

  // A result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_value) && $stable(out_status))
    else $error("stalled result changed");

  // A new result is only loaded while the input side is busy
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in flight");

  // An error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == urrs_pkg::STATUS_BAD_RANGE) |-> (out_sample_value == '0))
    else $error("error result with nonzero value");

endmodule

bind uniform_range_rejection_sampler urrs_checker u_urrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sample_value (out_ch.sample_value),
  .out_status       (out_ch.status)
);

`default_nettype wire
